[hdl/nested_counted_list_validator_core_defines.svh]
// Assertion macros for the validator
`ifndef NESTED_COUNTED_LIST_VALIDATOR_CORE_DEFINES_SVH
`define NESTED_COUNTED_LIST_VALIDATOR_CORE_DEFINES_SVH
`define NCLV_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
`define NCLV_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

[hdl/nclv_pkg.sv]
`default_nettype none
package nclv_pkg;
    localparam int COUNT_BITS = 17;
    localparam int LIMIT_BITS = 17;
    localparam int NUM_LISTS  = 19;
    localparam logic [7:0] PC_TOP   = 8'd10;
    localparam logic [7:0] PC_DONE  = 8'd12;
    localparam logic [7:0] PC_BASE  = 8'd13;
    localparam logic [7:0] PC_SLIST = 8'd26;
    localparam int ROM_LEN = 127;
    localparam logic [LIMIT_BITS-1:0] LARGE_RESET = 17'd100000;
    localparam logic [LIMIT_BITS-1:0] SMALL_RESET = 17'd10000;

    typedef enum logic [3:0] {
        OP_HDR, OP_TAG, OP_MAG, OP_SKIP, OP_CNT, OP_ZERO, OP_DTYPE,
        OP_LOOP, OP_CALL, OP_RET, OP_NEXT, OP_DONE
    } op_t;

    localparam logic [7:0] K_TOP = 8'd0;
    localparam logic [7:0] K_SL  = 8'd1;
    localparam logic [7:0] K_SS  = 8'd2;
    localparam logic [7:0] K_PL  = 8'd3;
    localparam logic [7:0] C_SEC = 8'd1;
    localparam logic [7:0] C_PTS = 8'd2;

    typedef enum logic [3:0] {
        ERR_NONE = 4'd0, ERR_HEADER = 4'd1, ERR_TAG = 4'd2, ERR_MAGIC = 4'd3,
        ERR_RANGE = 4'd4, ERR_RESERVED = 4'd5, ERR_DTYPE = 4'd6,
        ERR_FIXED = 4'd7, ERR_TRUNC = 4'd8, ERR_TRAIL = 4'd9
    } err_t;

    localparam logic [0:0] CFG_LARGE = 1'b0;
    localparam logic [0:0] CFG_SMALL = 1'b1;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic [3:0] aux;
    } seq_op_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       well_formed;
        logic [3:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic [7:0]            gs;
        logic [3:0]            rc;
        logic [6:0]            fbl;
        logic [4:0]            tli;
        logic [31:0]           ca;
        logic [COUNT_BITS-1:0] el;
        logic [COUNT_BITS-1:0] sl;
        logic [COUNT_BITS-1:0] pl;
        logic [3:0]            fe;
    } seq_state_t;

    function automatic seq_op_t mk(op_t o, logic [7:0] a, logic [3:0] x);
        seq_op_t r;
        r.op = o; r.arg = a; r.aux = x;
        return r;
    endfunction

    function automatic seq_op_t rom_fetch(logic [7:0] pc);
        seq_op_t r;
        unique case (pc)
            8'd0: r = mk(OP_HDR, 8'h00, 4'd0);
            8'd1: r = mk(OP_HDR, 8'h00, 4'd0);
            8'd2: r = mk(OP_HDR, 8'h00, 4'd0);
            8'd3: r = mk(OP_HDR, 8'h01, 4'd0);
            8'd4: r = mk(OP_HDR, 8'h0A, 4'd0);
            8'd5: r = mk(OP_HDR, 8'h01, 4'd0);
            8'd6: r = mk(OP_HDR, 8'h4C, 4'd0);
            8'd7: r = mk(OP_HDR, 8'h56, 4'd0);
            8'd8: r = mk(OP_HDR, 8'h44, 4'd0);
            8'd9: r = mk(OP_HDR, 8'h31, 4'd0);
            8'd10: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd11: r = mk(OP_CNT, K_TOP, 4'd0);
            8'd12: r = mk(OP_DONE, 8'd0, 4'd0);
            8'd13: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd14: r = mk(OP_SKIP, 8'd56, 4'd0);
            8'd15: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd16: r = mk(OP_SKIP, 8'd64, 4'd0);
            8'd17: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd18: r = mk(OP_SKIP, 8'd13, 4'd0);
            8'd19: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd20: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd21: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd22: r = mk(OP_SKIP, 8'd16, 4'd0);
            8'd23: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd24: r = mk(OP_SKIP, 8'd64, 4'd0);
            8'd25: r = mk(OP_RET, 8'd0, 4'd0);
            8'd26: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd27: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd28: r = mk(OP_CNT, K_SS, 4'd9);
            8'd29: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd30: r = mk(OP_SKIP, 8'd21, 4'd0);
            8'd31: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd32: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd33: r = mk(OP_CNT, K_PL, 4'd3);
            8'd34: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd35: r = mk(OP_SKIP, 8'd8, 4'd0);
            8'd36: r = mk(OP_LOOP, C_PTS, 4'd2);
            8'd37: r = mk(OP_LOOP, C_SEC, 4'd8);
            8'd38: r = mk(OP_RET, 8'd0, 4'd0);
            8'd39: r = mk(OP_MAG, 8'h03, 4'd0);
            8'd40: r = mk(OP_CALL, PC_BASE, 4'd0);
            8'd41: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd42: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd43: r = mk(OP_CNT, K_SL, 4'd3);
            8'd44: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd45: r = mk(OP_SKIP, 8'd8, 4'd0);
            8'd46: r = mk(OP_LOOP, C_SEC, 4'd2);
            8'd47: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd48: r = mk(OP_CNT, K_SL, 4'd3);
            8'd49: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd50: r = mk(OP_SKIP, 8'd8, 4'd0);
            8'd51: r = mk(OP_LOOP, C_SEC, 4'd2);
            8'd52: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd53: r = mk(OP_CNT, K_SS, 4'd5);
            8'd54: r = mk(OP_MAG, 8'h03, 4'd0);
            8'd55: r = mk(OP_CALL, PC_BASE, 4'd1);
            8'd56: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd57: r = mk(OP_SKIP, 8'd16, 4'd0);
            8'd58: r = mk(OP_LOOP, C_SEC, 4'd4);
            8'd59: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd60: r = mk(OP_CNT, K_SL, 4'd3);
            8'd61: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd62: r = mk(OP_SKIP, 8'd12, 4'd0);
            8'd63: r = mk(OP_LOOP, C_SEC, 4'd2);
            8'd64: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd65: r = mk(OP_MAG, 8'h02, 4'd0);
            8'd66: r = mk(OP_CALL, PC_BASE, 4'd2);
            8'd67: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd68: r = mk(OP_SKIP, 8'd8, 4'd0);
            8'd69: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd70: r = mk(OP_MAG, 8'h02, 4'd0);
            8'd71: r = mk(OP_CALL, PC_BASE, 4'd3);
            8'd72: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd73: r = mk(OP_SKIP, 8'd16, 4'd0);
            8'd74: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd75: r = mk(OP_MAG, 8'h03, 4'd0);
            8'd76: r = mk(OP_CALL, PC_BASE, 4'd4);
            8'd77: r = mk(OP_CALL, PC_SLIST, 4'd5);
            8'd78: r = mk(OP_CALL, PC_SLIST, 4'd6);
            8'd79: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd80: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd81: r = mk(OP_ZERO, 8'd0, 4'd0);
            8'd82: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd83: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd84: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd85: r = mk(OP_CNT, K_SL, 4'd3);
            8'd86: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd87: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd88: r = mk(OP_LOOP, C_SEC, 4'd2);
            8'd89: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd90: r = mk(OP_ZERO, 8'd0, 4'd0);
            8'd91: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd92: r = mk(OP_CNT, K_SL, 4'd2);
            8'd93: r = mk(OP_SKIP, 8'd5, 4'd0);
            8'd94: r = mk(OP_LOOP, C_SEC, 4'd1);
            8'd95: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd96: r = mk(OP_MAG, 8'h01, 4'd0);
            8'd97: r = mk(OP_CALL, PC_BASE, 4'd7);
            8'd98: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd99: r = mk(OP_DTYPE, 8'd0, 4'd0);
            8'd100: r = mk(OP_SKIP, 8'd33, 4'd0);
            8'd101: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd102: r = mk(OP_MAG, 8'h01, 4'd0);
            8'd103: r = mk(OP_CALL, PC_BASE, 4'd8);
            8'd104: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd105: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd106: r = mk(OP_CALL, PC_SLIST, 4'd9);
            8'd107: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd108: r = mk(OP_MAG, 8'h01, 4'd0);
            8'd109: r = mk(OP_CALL, PC_BASE, 4'd10);
            8'd110: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd111: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd112: r = mk(OP_SKIP, 8'd21, 4'd0);
            8'd113: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd114: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd115: r = mk(OP_CNT, K_PL, 4'd3);
            8'd116: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd117: r = mk(OP_SKIP, 8'd8, 4'd0);
            8'd118: r = mk(OP_LOOP, C_PTS, 4'd2);
            8'd119: r = mk(OP_NEXT, 8'd0, 4'd0);
            8'd120: r = mk(OP_MAG, 8'h01, 4'd0);
            8'd121: r = mk(OP_CALL, PC_BASE, 4'd11);
            8'd122: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd123: r = mk(OP_SKIP, 8'd4, 4'd0);
            8'd124: r = mk(OP_TAG, 8'd0, 4'd0);
            8'd125: r = mk(OP_SKIP, 8'd32, 4'd0);
            8'd126: r = mk(OP_NEXT, 8'd0, 4'd0);
            default: r = mk(OP_DONE, 8'd0, 4'd0);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ret_pc(logic [3:0] c);
        logic [7:0] r;
        unique case (c)
            4'd0: r = 8'd41;   4'd1: r = 8'd56;   4'd2: r = 8'd67;
            4'd3: r = 8'd72;   4'd4: r = 8'd77;   4'd5: r = 8'd78;
            4'd6: r = 8'd79;   4'd7: r = 8'd98;   4'd8: r = 8'd104;
            4'd9: r = 8'd107;  4'd10: r = 8'd110; 4'd11: r = 8'd122;
            default: r = PC_DONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] entry_pc(logic [4:0] i);
        logic [7:0] r;
        unique case (i)
            5'd0: r = 8'd39;  5'd1: r = 8'd65;  5'd2: r = 8'd65;
            5'd3: r = 8'd70;  5'd4: r = 8'd70;  5'd5: r = 8'd75;
            5'd11: r = 8'd96; 5'd12: r = 8'd102; 5'd13: r = 8'd108;
            5'd14: r = 8'd120;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // pos 1..11 of magic, index pos-1
    function automatic logic [7:0] magic_tail(logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h04; 4'd1: r = 8'h01; 4'd2: r = 8'h01; 4'd3: r = 8'h77;
            4'd4: r = 8'h35; 4'd5: r = 8'hbb; 4'd6: r = 8'h75; 4'd7: r = 8'h00;
            4'd8: r = 8'h00; 4'd9: r = 8'h00; 4'd10: r = 8'h02;
            default: r = 8'h00;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hdl/nclv_resolve.sv]
`default_nettype none
// Advances through control ops (loop, call, return, next) until a byte op.
// Control chains are short: at most a few ops before the next consuming op.
module nclv_resolve
    import nclv_pkg::*;
(
    input  wire seq_state_t st_in,
    output seq_state_t      st_out
);
    function automatic seq_state_t step(seq_state_t s);
        seq_state_t r;
        seq_op_t    o;
        logic [7:0] ep;
        r  = s;
        o  = rom_fetch(s.gs);
        ep = entry_pc(s.tli);
        unique case (o.op)
            OP_LOOP:
            begin
                if (o.arg == C_PTS)
                begin
                    r.pl = s.pl - 1'b1;
                    r.gs = (r.pl != '0) ? s.gs - {4'd0, o.aux} : s.gs + 8'd1;
                end
                else
                begin
                    r.sl = s.sl - 1'b1;
                    r.gs = (r.sl != '0) ? s.gs - {4'd0, o.aux} : s.gs + 8'd1;
                end
            end
            OP_CALL:
            begin
                r.rc = o.aux;
                r.gs = o.arg;
            end
            OP_RET: r.gs = ret_pc(s.rc);
            OP_NEXT:
            begin
                r.el = s.el - 1'b1;
                if (r.el != '0 && ep != 8'd0)
                    r.gs = ep;
                else
                begin
                    r.tli = s.tli + 5'd1;
                    r.gs  = (r.tli >= 5'(NUM_LISTS)) ? PC_DONE : PC_TOP;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    // worst chain: point loop, section loop, ret, call (slist) -> 4 ops
    always_comb
    begin
        st_out = step(step(step(step(st_in))));
    end
endmodule
`default_nettype wire

[hdl/nclv_consume.sv]
`default_nettype none
// Handles one byte at a resolved byte op.
module nclv_consume
    import nclv_pkg::*;
(
    input  wire seq_state_t            st_in,
    input  wire logic [7:0]            data_byte,
    input  wire logic [LIMIT_BITS-1:0] large_lim,
    input  wire logic [LIMIT_BITS-1:0] small_lim,
    output seq_state_t                 st_out
);
    seq_op_t     o;
    logic [6:0]  len;
    logic [6:0]  fbl;
    logic [6:0]  pos;
    logic [7:0]  want;
    logic [31:0] v;
    logic [7:0]  ep;
    logic        ok;
    logic [31:0] lim;

    always_comb
    begin
        st_out = st_in;
        o    = rom_fetch(st_in.gs);
        ep   = entry_pc(st_in.tli);
        len  = (o.op == OP_MAG) ? 7'd12 :
               (o.op == OP_SKIP) ? ((o.arg != 8'd0) ? o.arg[6:0] : 7'd1) : 7'd4;
        fbl  = (st_in.fbl == 7'd0 || st_in.fbl > len) ? len : st_in.fbl;
        pos  = len - fbl;
        want = (pos == 7'd0) ? o.arg : magic_tail(4'(pos - 7'd1));
        v    = {st_in.ca[23:0], data_byte};
        lim  = {15'd0, ((o.arg == K_SS) ? small_lim : large_lim)};
        ok   = !v[31] && v <= lim && v <= 32'((64'd1 << COUNT_BITS) - 64'd1);
        unique case (o.op)
            OP_HDR:
                if (data_byte != o.arg) st_out.fe = ERR_HEADER;
                else st_out.gs = st_in.gs + 8'd1;
            OP_TAG:
                if (data_byte != 8'h01) st_out.fe = ERR_TAG;
                else st_out.gs = st_in.gs + 8'd1;
            OP_DONE: st_out.fe = ERR_TRAIL;
            OP_MAG, OP_SKIP, OP_CNT, OP_ZERO, OP_DTYPE:
            begin
                st_out.fbl = fbl;
                if (o.op == OP_MAG && data_byte != want)
                    st_out.fe = ERR_MAGIC;
                else
                begin
                    st_out.ca  = v;
                    st_out.fbl = fbl - 7'd1;
                    if (st_out.fbl == 7'd0)
                    begin
                        if (o.op == OP_CNT)
                        begin
                            if (!ok)
                                st_out.fe = ERR_RANGE;
                            else if (o.arg == K_TOP)
                            begin
                                if (ep == 8'd0 && v != 32'd0)
                                    st_out.fe = ERR_RESERVED;
                                else if (v == 32'd0)
                                begin
                                    st_out.tli = st_in.tli + 5'd1;
                                    st_out.gs  = (st_out.tli >= 5'(NUM_LISTS)) ?
                                                 PC_DONE : PC_TOP;
                                end
                                else
                                begin
                                    st_out.el = v[COUNT_BITS-1:0];
                                    st_out.gs = ep;
                                end
                            end
                            else if (v == 32'd0)
                                st_out.gs = st_in.gs + 8'd1 + {4'd0, o.aux};
                            else
                            begin
                                if (o.arg == K_PL) st_out.pl = v[COUNT_BITS-1:0];
                                else st_out.sl = v[COUNT_BITS-1:0];
                                st_out.gs = st_in.gs + 8'd1;
                            end
                        end
                        else if (o.op == OP_ZERO && v != 32'd0)
                            st_out.fe = ERR_FIXED;
                        else if (o.op == OP_DTYPE && v != 32'd2 && v != 32'd3)
                            st_out.fe = ERR_DTYPE;
                        else
                            st_out.gs = st_in.gs + 8'd1;
                    end
                end
            end
            default: st_out = st_in;
        endcase
    end
endmodule
`default_nettype wire

[hdl/nested_counted_list_validator_core.sv]
// A verdict beat appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle unless stalled; the grammar step (resolve,
// then byte) is combinational between the sequencer state and the output
// register, which holds a verdict while non-final bytes keep flowing.
// Reset: asynchronous, active low; sequencer clears, limits go to 100000/10000.
`default_nettype none
`include "nested_counted_list_validator_core_defines.svh"
module nested_counted_list_validator_core
    import nclv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);
    seq_state_t            st_reg, st_next;
    seq_state_t            st_pre, st_cons;
    logic [LIMIT_BITS-1:0] large_reg, small_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;
    logic                  acc;
    logic [3:0]            code;

    assign cfg_ready = 1'b1;
    // Stall only when a verdict still waits and this beat would make another.
    assign in_stall  = out_valid_reg && out_stall && in_data.last_byte;
    assign acc       = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // pending control ops are walked before the byte; ops left behind by a
    // finished field are walked at the next byte
    nclv_resolve u_pre (.st_in(st_reg), .st_out(st_pre));
    nclv_consume u_cons
    (
        .st_in(st_pre), .data_byte(in_data.data_byte),
        .large_lim(large_reg), .small_lim(small_reg),
        .st_out(st_cons)
    );

    always_comb
    begin
        st_next = st_reg;
        if (st_reg.fe == ERR_NONE)
            st_next = st_cons;
        code = st_next.fe;
        if (code == ERR_NONE && st_next.gs != PC_DONE)
            code = ERR_TRUNC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            large_reg     <= LARGE_RESET;
            small_reg     <= SMALL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LARGE) large_reg <= cfg_data[LIMIT_BITS-1:0];
                else small_reg <= cfg_data[LIMIT_BITS-1:0];
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (acc)
            begin
                if (in_data.last_byte)
                begin
                    st_reg        <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                    st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && in_data.last_byte)
        begin
            out_reg.well_formed <= (code == ERR_NONE);
            out_reg.error_code  <= code;
        end
    end

    `NCLV_ASSERT_IMP(a_wf_code, out_valid, out_data.well_formed == (out_data.error_code == ERR_NONE), "verdict flag disagrees with code")
    `NCLV_ASSERT_IMP(a_code_range, out_valid, out_data.error_code <= ERR_TRAIL, "code out of range")
    `NCLV_ASSERT_NXT(a_sticky, acc && !in_data.last_byte && st_reg.fe != ERR_NONE, st_reg.fe == $past(st_reg.fe), "first error lost")
    `NCLV_ASSERT_NXT(a_restart, acc && in_data.last_byte, out_valid && st_reg.gs == 8'd0, "no restart after verdict")
endmodule
`default_nettype wire
